// ----- rtl/core/tphc_pkg.sv -----
// tphc_pkg: shared types, constants and the ones'-complement add for the
// TCP pseudo-header checksum block. No dependencies.
package tphc_pkg;

    localparam int SUM_W = 16;
    localparam int ADDR_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_ADDRESS = 2'd1;

    localparam logic [SUM_W-1:0] PROTOCOL_TCP = 16'd6;

    // One finished segment handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;      // running sum including the last pair
        logic [SUM_W-1:0] pad_word; // odd trailing byte padded, or zero
        logic [SUM_W-1:0] count;    // byte count, zero-extended
    } seg_rec_t;

    // 16-bit ones'-complement add with end-around carry.
    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SUM_W])
        begin
            oc_add = s[SUM_W-1:0] + 16'd1;
        end
        else
        begin
            oc_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/tphc_front.sv -----
// tphc_front: accepts segment bytes, pairs them into words, keeps the running
// ones'-complement sum and byte count. Depends on tphc_pkg.
module tphc_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  rec_push,
    output tphc_pkg::seg_rec_t    rec
);

    logic [tphc_pkg::SUM_W-1:0] sum_reg;
    logic [tphc_pkg::SUM_W-1:0] sum_next;
    logic [7:0]                 held_reg;
    logic [7:0]                 held_next;
    logic                       odd_reg;
    logic                       odd_next;
    logic [LENGTH_BITS-1:0]     count_reg;
    logic [LENGTH_BITS-1:0]     count_next;

    logic [tphc_pkg::SUM_W-1:0] sum_after;
    logic [LENGTH_BITS-1:0]     count_after;

    assign sum_after = odd_reg ? tphc_pkg::oc_add(sum_reg, {held_reg, data_byte}) : sum_reg;
    assign count_after = count_reg + LENGTH_BITS'(1);

    always_comb
    begin
        sum_next = sum_reg;
        held_next = held_reg;
        odd_next = odd_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                // drop stream state, segment goes to the queue
                sum_next = '0;
                held_next = '0;
                odd_next = 1'b0;
                count_next = '0;
            end
            else
            begin
                sum_next = sum_after;
                held_next = odd_reg ? held_reg : data_byte;
                odd_next = ~odd_reg;
                count_next = count_after;
            end
        end
    end

    assign rec_push = accept & last_byte;
    assign rec.sum = sum_after;
    assign rec.pad_word = odd_reg ? '0 : {data_byte, 8'h00};
    assign rec.count = tphc_pkg::SUM_W'(count_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            held_reg <= '0;
            odd_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            held_reg <= held_next;
            odd_reg <= odd_next;
            count_reg <= count_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> (!odd_reg && count_reg == '0 && sum_reg == '0))
        else $error("stream state not cleared after last byte");

endmodule

// ----- rtl/core/tphc_queue.sv -----
// tphc_queue: short queue of finished segment records between front and back.
// Depends on tphc_pkg.
module tphc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tphc_pkg::seg_rec_t    wr_rec,
    output logic                  full,
    input  logic                  pop,
    output tphc_pkg::seg_rec_t    rd_rec,
    output logic                  empty
);

    tphc_pkg::seg_rec_t          entry_reg [tphc_pkg::QUEUE_DEPTH];
    logic [tphc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tphc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tphc_pkg::QCNT_W-1:0] count_reg;
    logic [tphc_pkg::QCNT_W-1:0] count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full = (count_reg == tphc_pkg::QCNT_W'(tphc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop = pop & ~empty;
    assign rd_rec = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tphc_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - tphc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tphc_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tphc_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tphc_pkg::QCNT_W'(tphc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("segment record pushed into full queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/tphc_back.sv -----
// tphc_back: adds the pseudo-header to a finished segment sum, folds, inverts
// and holds the result. Depends on tphc_pkg.
module tphc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [tphc_pkg::ADDR_W-1:0]        source_address,
    input  logic [tphc_pkg::ADDR_W-1:0]        destination_address,
    input  logic                               rec_valid,
    input  tphc_pkg::seg_rec_t                 rec,
    output logic                               rec_take,
    output logic                               res_valid,
    input  logic                               res_take,
    output logic [tphc_pkg::SUM_W-1:0]         checksum,
    output logic [tphc_pkg::SUM_W-1:0]         segment_length
);

    localparam int PART_W = tphc_pkg::SUM_W + 2;
    localparam int TOT_W = tphc_pkg::SUM_W + 3;
    localparam int FOLD_W = tphc_pkg::SUM_W + 1;

    // stage A: two partial sums of four words each
    logic                         a_v_reg;
    logic [PART_W-1:0]            a_p_reg;
    logic [PART_W-1:0]            a_q_reg;
    logic [tphc_pkg::SUM_W-1:0]   a_len_reg;
    // stage B: full binary sum
    logic                         b_v_reg;
    logic [TOT_W-1:0]             b_t_reg;
    logic [tphc_pkg::SUM_W-1:0]   b_len_reg;
    // stage C: first fold
    logic                         c_v_reg;
    logic [FOLD_W-1:0]            c_f_reg;
    logic [tphc_pkg::SUM_W-1:0]   c_len_reg;
    // stage D: result
    logic                         d_v_reg;
    logic [tphc_pkg::SUM_W-1:0]   d_sum_reg;
    logic [tphc_pkg::SUM_W-1:0]   d_len_reg;

    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic d_ready;
    logic [PART_W-1:0] p_next;
    logic [PART_W-1:0] q_next;

    assign d_ready = ~d_v_reg | res_take;
    assign c_ready = ~c_v_reg | d_ready;
    assign b_ready = ~b_v_reg | c_ready;
    assign a_ready = ~a_v_reg | b_ready;
    assign rec_take = rec_valid & a_ready;

    assign p_next = PART_W'(rec.sum) + PART_W'(rec.pad_word)
                  + PART_W'(source_address[31:16]) + PART_W'(source_address[15:0]);
    assign q_next = PART_W'(destination_address[31:16])
                  + PART_W'(destination_address[15:0])
                  + PART_W'(tphc_pkg::PROTOCOL_TCP) + PART_W'(rec.count);

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_p_reg <= p_next;
            a_q_reg <= q_next;
            a_len_reg <= rec.count;
        end
        if (b_ready)
        begin
            b_t_reg <= TOT_W'(a_p_reg) + TOT_W'(a_q_reg);
            b_len_reg <= a_len_reg;
        end
        if (c_ready)
        begin
            c_f_reg <= FOLD_W'(b_t_reg[tphc_pkg::SUM_W-1:0])
                     + FOLD_W'(b_t_reg[TOT_W-1:tphc_pkg::SUM_W]);
            c_len_reg <= b_len_reg;
        end
        if (d_ready)
        begin
            // second fold cannot carry again; invert into the checksum
            d_sum_reg <= ~(c_f_reg[tphc_pkg::SUM_W-1:0]
                         + tphc_pkg::SUM_W'(c_f_reg[tphc_pkg::SUM_W]));
            d_len_reg <= c_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_v_reg <= rec_valid;
            end
            if (b_ready)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_ready)
            begin
                c_v_reg <= b_v_reg;
            end
            if (d_ready)
            begin
                d_v_reg <= c_v_reg;
            end
        end
    end

    assign res_valid = d_v_reg;
    assign checksum = d_sum_reg;
    assign segment_length = d_len_reg;

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && !b_ready) |=> (b_v_reg && $stable(b_t_reg)))
        else $error("stalled sum stage lost its request");

    a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg |-> (c_f_reg[tphc_pkg::SUM_W] == 1'b0 || c_f_reg[tphc_pkg::SUM_W-1:3] == '0))
        else $error("first fold out of range");

endmodule

// ----- rtl/core/tcp_pseudo_header_checksum.sv -----
// tcp_pseudo_header_checksum: top level; holds the address registers and joins
// front, queue and back. Depends on tphc_pkg, tphc_front, tphc_queue, tphc_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | push / full               | data_byte[7:0], last_byte
//  result   | empty / pop               | checksum[15:0], segment_length[15:0]
//  config   | cfg_we (no wait)          | cfg_index[1:0], cfg_data[31:0]
//
// One byte is taken every cycle while full is low; the running sum updates in the same cycle.
// A last byte queues its segment record, which then passes back stages A, B, C and D.
// full rises only when the four-entry segment queue is full, i.e. while
// results back up behind pop; short segments then stall at the input.
// Reset clears the addresses, the stream state, the queue and the pipeline.
module tcp_pseudo_header_checksum #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [15:0]                       checksum,
    output logic [15:0]                       segment_length,
    input  logic                              cfg_we,
    input  logic [tphc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tphc_pkg::ADDR_W-1:0]       cfg_data
);

    logic [tphc_pkg::ADDR_W-1:0] src_addr_reg;
    logic [tphc_pkg::ADDR_W-1:0] dst_addr_reg;

    logic                accept;
    logic                rec_push;
    tphc_pkg::seg_rec_t  wr_rec;
    tphc_pkg::seg_rec_t  rd_rec;
    logic                q_full;
    logic                q_empty;
    logic                rec_take;
    logic                res_valid;

    assign full = q_full;
    assign accept = push & ~q_full;
    assign empty = ~res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tphc_pkg::REG_SOURCE_ADDRESS)
            begin
                src_addr_reg <= cfg_data;
            end
            else if (cfg_index == tphc_pkg::REG_DESTINATION_ADDRESS)
            begin
                dst_addr_reg <= cfg_data;
            end
        end
    end

    tphc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec_push  (rec_push),
        .rec       (wr_rec)
    );

    tphc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (rec_push),
        .wr_rec (wr_rec),
        .full   (q_full),
        .pop    (rec_take),
        .rd_rec (rd_rec),
        .empty  (q_empty)
    );

    tphc_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .source_address      (src_addr_reg),
        .destination_address (dst_addr_reg),
        .rec_valid           (~q_empty),
        .rec                 (rd_rec),
        .rec_take            (rec_take),
        .res_valid           (res_valid),
        .res_take            (pop),
        .checksum            (checksum),
        .segment_length      (segment_length)
    );

endmodule
